[hw/rtl/jacobi_symbol_binary_core_macros.svh]
// Assertion helpers shared by the datapath and the top-level RTL files.
// Every module that uses them has clk_i and rst_ni.
`ifndef JACOBI_SYMBOL_BINARY_CORE_MACROS_SVH
`define JACOBI_SYMBOL_BINARY_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define JSB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check an implication whose consequent is checked in the next cycle.
`define JSB_ASSERT_NEXT(label, cond, prop, msg) \
  `JSB_ASSERT(label, (cond) |=> (prop), msg)

`endif

[hw/rtl/jsb_pkg.sv]
`timescale 1ns / 1ps

package jsb_pkg;

  // Operand width used by the datapath; ports stay at the full field width.
  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned FIELD_BITS = 64;

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [FIELD_BITS-1:0] field_t;

  // Symbol codes, two's complement.
  localparam logic [1:0] SYM_ZERO = 2'b00;
  localparam logic [1:0] SYM_POS  = 2'b01;
  localparam logic [1:0] SYM_NEG  = 2'b11;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic a_zero;
    logic n_odd;
    logic lt;
    logic n_one;
    logic flip;
  } sts_t;

  // Result hand-off from the sequencer to the output register.
  typedef struct packed {
    logic load;
    logic bad;
  } res_t;

endpackage

[hw/rtl/jsb_datapath.sv]
`timescale 1ns / 1ps
`include "jacobi_symbol_binary_core_macros.svh"

module jsb_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  jsb_pkg::cmd_t   cmd_i,
  input  jsb_pkg::word_t  residue_i,
  input  jsb_pkg::word_t  modulus_i,
  output jsb_pkg::sts_t   sts_o
);

  jsb_pkg::word_t a_q, a_d;
  jsb_pkg::word_t n_q, n_d;
  logic           flip_q, flip_d;

  // Shared unit: compare, order the operands, subtract the smaller.
  logic           lt;
  jsb_pkg::word_t op_hi;
  jsb_pkg::word_t op_lo;
  jsb_pkg::word_t diff;

  assign lt    = a_q < n_q;
  assign op_hi = lt ? n_q : a_q;
  assign op_lo = lt ? a_q : n_q;
  assign diff  = op_hi - op_lo;

  // Next operand values: load, halve an even a, or swap and subtract.
  always_comb begin
    a_d    = a_q;
    n_d    = n_q;
    flip_d = flip_q;
    if (cmd_i.load) begin
      a_d    = residue_i;
      n_d    = modulus_i;
      flip_d = 1'b0;
    end else if (cmd_i.step) begin
      if (!a_q[0]) begin
        a_d = a_q >> 1;
        if (n_q[2:0] == 3'd3 || n_q[2:0] == 3'd5) begin
          flip_d = ~flip_q;
        end
      end else begin
        a_d = diff;
        if (lt) begin
          n_d = a_q;
          if (a_q[1:0] == 2'b11 && n_q[1:0] == 2'b11) begin
            flip_d = ~flip_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    n_q    <= n_d;
    flip_q <= flip_d;
  end

  assign sts_o.a_zero = (a_q == '0);
  assign sts_o.n_odd  = n_q[0];
  assign sts_o.lt     = lt;
  assign sts_o.n_one  = (n_q == jsb_pkg::word_t'(1));
  assign sts_o.flip   = flip_q;

  // An odd n stays odd through every round.
  `JSB_ASSERT_NEXT(a_n_stays_odd, cmd_i.step && n_q[0], n_q[0], "n lost its odd bit")
  // A subtract round always leaves an even a.
  `JSB_ASSERT_NEXT(a_sub_gives_even, cmd_i.step && a_q[0] && n_q[0], !a_q[0],
                   "subtract left an odd value")
  // A halving round never grows a.
  `JSB_ASSERT_NEXT(a_shift_shrinks, cmd_i.step && !a_q[0], a_q <= $past(a_q),
                   "halving grew the operand")

endmodule

[hw/rtl/jsb_ctrl.sv]
`timescale 1ns / 1ps

module jsb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  jsb_pkg::sts_t  sts_i,
  input  logic           out_free_i,
  output jsb_pkg::cmd_t  cmd_o,
  output jsb_pkg::res_t  res_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   bad_q, bad_d;

  // Sequence: load, range check, rounds until a is zero (skipped for a bad request), hand off.
  always_comb begin
    state_d    = state_q;
    bad_d      = bad_q;
    cmd_o      = '0;
    res_o.load = 1'b0;
    res_o.bad  = bad_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        bad_d   = !sts_i.n_odd || !sts_i.lt;
        state_d = bad_d ? ST_DONE : ST_RUN;
      end
      ST_RUN: begin
        if (sts_i.a_zero) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          res_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bad_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      bad_q   <= bad_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

[hw/rtl/jacobi_symbol_binary_core.sv]
`timescale 1ns / 1ps
`include "jacobi_symbol_binary_core_macros.svh"
// Jacobi symbol (residue / modulus) by the binary subtract-and-shift method.
// Configuration: cfg_we_i writes cfg_wdata_i into the modulus register at a
// clock edge; write it only while no request is in flight.
// Input channel: residue_i is taken at an edge with in_valid_i high and
// in_stall_o low. The block holds in_stall_o high while it works on it.
// Output channel: symbol_o (-1, 0, 1 in two's complement) and bad_input_o
// are taken at an edge with out_valid_o high and out_stall_i low.
// bad_input_o is set, with symbol 0, for an even modulus or residue >= modulus.
// Sequence: the range check, then one round per cycle on the shared
// compare/subtract unit, then the done state and the output register. A halving
// round strips one factor of two, a subtract round reduces the larger odd
// operand; up to about 127 halving and 65 subtract rounds for 64-bit operands.
// A bad request skips the rounds and goes from the range check to the hand-off.
// The block takes one request at a time and finishes it first. A new request is taken
// once the previous result sits in the output register, even while the
// receiver stalls it; a stalled result holds.
// Reset clears the handshake state and sets the modulus to 1.

module jacobi_symbol_binary_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [63:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [63:0]        residue_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [1:0]  symbol_o,
  output logic               bad_input_o
);

  jsb_pkg::field_t modulus_q;
  jsb_pkg::cmd_t   cmd;
  jsb_pkg::sts_t   sts;
  jsb_pkg::res_t   res;
  logic            out_valid_q;
  logic [1:0]      symbol_q, symbol_d;
  logic            bad_q;
  logic            out_free;

  // Hold the modulus register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= jsb_pkg::field_t'(1);
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i;
    end
  end

  jsb_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .residue_i (residue_i[jsb_pkg::WORD_BITS-1:0]),
    .modulus_i (modulus_q[jsb_pkg::WORD_BITS-1:0]),
    .sts_o     (sts)
  );

  jsb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .out_free_i (out_free),
    .cmd_o      (cmd),
    .res_o      (res)
  );

  // Form the symbol from the final n and the sign flag.
  always_comb begin
    if (res.bad || !sts.n_one) begin
      symbol_d = jsb_pkg::SYM_ZERO;
    end else if (sts.flip) begin
      symbol_d = jsb_pkg::SYM_NEG;
    end else begin
      symbol_d = jsb_pkg::SYM_POS;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // Advance the output register; drop valid once the result is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.load) begin
      symbol_q <= symbol_d;
      bad_q    <= res.bad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign symbol_o    = $signed(symbol_q);
  assign bad_input_o = bad_q;

  `JSB_ASSERT(a_sym_code, !out_valid_o || symbol_o != 2'sb10, "invalid symbol code")
  `JSB_ASSERT(a_bad_zero, !(out_valid_o && bad_input_o) || symbol_o == 2'sb00,
              "bad input with nonzero symbol")
  `JSB_ASSERT_NEXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o,
                   "request taken while busy clear")

endmodule

[tb/jacobi_checker.sv]
`timescale 1ns / 1ps

// Watch the request and result channels, predict each symbol and compare.
module jacobi_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [63:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [63:0]       residue_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic signed [1:0] symbol_i,
  input  logic              bad_input_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  typedef struct packed {
    logic [1:0] symbol;
    logic       bad;
  } jacobi_result_t;

  jacobi_result_t expected_q[$];
  logic [63:0]    modulus_q = 64'd1;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // Binary subtract-and-shift walk; a and n must satisfy n odd, a < n.
  function automatic logic [1:0] jacobi_symbol(logic [63:0] x, logic [63:0] m);
    logic [63:0] a;
    logic [63:0] n;
    logic [63:0] t;
    logic        flip;
    a    = x;
    n    = m;
    flip = 1'b0;
    while (a != 64'd0) begin
      // strip twos; each one flips when n is 3 or 5 mod 8
      while (a[0] == 1'b0) begin
        a = a >> 1;
        if (n[2:0] == 3'd3 || n[2:0] == 3'd5) flip = ~flip;
      end
      // swap so that a is the larger; reciprocity flip when both are 3 mod 4
      if (a < n) begin
        t = a;
        a = n;
        n = t;
        if (a[1:0] == 2'b11 && n[1:0] == 2'b11) flip = ~flip;
      end
      a = a - n;
    end
    if (n != 64'd1) return jsb_pkg::SYM_ZERO;
    return flip ? jsb_pkg::SYM_NEG : jsb_pkg::SYM_POS;
  endfunction

  function automatic jacobi_result_t predict_result(logic [63:0] modulus,
                                                    logic [63:0] residue);
    logic [63:0]    mask;
    logic [63:0]    m;
    logic [63:0]    x;
    jacobi_result_t res;
    mask = {64{1'b1}} >> (64 - jsb_pkg::WORD_BITS);
    m    = modulus & mask;
    x    = residue & mask;
    if (m[0] == 1'b0 || x >= m) begin
      res.symbol = jsb_pkg::SYM_ZERO;
      res.bad    = 1'b1;
    end else begin
      res.symbol = jacobi_symbol(x, m);
      res.bad    = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    jacobi_result_t want;
    if (!rst_ni) begin
      modulus_q = 64'd1;
      expected_q.delete();
    end else begin
      // queue the prediction for an accepted request
      if (in_valid_i && !in_stall_i) expected_q.push_back(predict_result(modulus_q, residue_i));

      // compare an accepted result against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: symbol %0d, bad_input %0b", symbol_i, bad_input_i);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (symbol_i !== want.symbol) begin
            $error("symbol: expected %0d, actual %0d", $signed(want.symbol), symbol_i);
            fail_count_o++;
          end
          if (bad_input_i !== want.bad) begin
            $error("bad_input: expected %0b, actual %0b", want.bad, bad_input_i);
            fail_count_o++;
          end
        end
      end

      // track the modulus register
      if (cfg_we_i) modulus_q = cfg_wdata_i;
    end
    pending_o = expected_q.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam logic [63:0] ALL_ONES = {64{1'b1}};

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [63:0]       cfg_wdata_i = 64'd0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [63:0]       residue_i   = 64'd0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic signed [1:0] symbol_o;
  logic              bad_input_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic [63:0] modulus_now = 64'd1;

  always #5 clk_i = ~clk_i;

  jacobi_symbol_binary_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .residue_i   (residue_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .symbol_o    (symbol_o),
    .bad_input_o (bad_input_o)
  );

  jacobi_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .residue_i    (residue_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .symbol_i     (symbol_o),
    .bad_input_i  (bad_input_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Stall the result channel at the current rate
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Offer one request and hold it until accepted; leave valid high afterwards
  task automatic send_residue(logic [63:0] x);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      if ($urandom_range(1)) repeat ($urandom_range(1, 4)) @(posedge clk_i);
      else repeat ($urandom_range(5, 140)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    residue_i  <= x;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and wait until every request has its result back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_modulus(logic [63:0] value);
    drain();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    modulus_now = value;
  endtask

  function automatic logic [63:0] pick_modulus();
    case ($urandom_range(9))
      0:       return rand_word() & ~64'd1;
      1:       return ALL_ONES;
      2:       return 64'($urandom_range(1, 63) | 1);
      3:       return {32'd0, $urandom | 32'd1};
      default: return rand_word() | 64'd1;
    endcase
  endfunction

  function automatic logic [63:0] pick_residue(logic [63:0] m);
    logic [63:0] r;
    r = rand_word();
    if (m == 64'd0) return r;
    case ($urandom_range(9))
      0:       return r;
      1:       return m - 64'd1;
      2:       return 64'($urandom_range(16));
      3:       return ((r % m) >> $urandom_range(1, 40)) << $urandom_range(1, 20);
      4:       return m + 64'($urandom_range(3));
      default: return r % m;
    endcase
  endfunction

  // Give up after a generous bound
  initial begin
    #40_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    logic [63:0] m;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // modulus one after reset: only zero is in range
    send_residue(64'd0);
    send_residue(64'd1);
    send_residue(ALL_ONES);

    // largest odd modulus
    write_modulus(ALL_ONES);
    send_residue(64'd0);
    send_residue(64'd1);
    send_residue(64'd2);
    send_residue(64'd3);
    send_residue(ALL_ONES - 64'd1);
    send_residue(ALL_ONES);
    send_residue(64'h8000_0000_0000_0000);
    send_residue(64'h5555_5555_5555_5555);
    send_residue(64'hAAAA_AAAA_AAAA_AAAA);

    // even moduli, zero among them
    write_modulus(64'd0);
    send_residue(64'd0);
    write_modulus(64'hFFFF_FFFF_FFFF_FFFE);
    send_residue(64'd1);

    // small composite modulus: shared factor, powers of two, edge of range
    write_modulus(64'd15);
    send_residue(64'd3);
    send_residue(64'd2);
    send_residue(64'd8);
    send_residue(64'd14);
    send_residue(64'd15);

    // random part in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      drain();
      send_idle_pct  = (phase == 0) ? 19 : (phase == 1) ? 82 : 0;
      recv_stall_pct = (phase == 0) ? 82 : (phase == 1) ? 19 : 0;
      for (int grp = 0; grp < 14; grp++) begin
        m = pick_modulus();
        write_modulus(m);
        repeat (19) send_residue(pick_residue(modulus_now));
      end
    end

    // hold off until all results are back, then let the block settle
    drain();
    repeat (140) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
